### rtl/stdc_pkg.sv
// shared constants and types for the sphere table contact search
package stdc_pkg;
  localparam int unsigned Capacity  = 4096;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned IdxBits   = 12;
  localparam int unsigned CntBits   = 13;
  localparam int unsigned SqBits    = 2 * (CoordBits + 1);
  localparam int unsigned RootBits  = CoordBits + 1;

  typedef enum logic [1:0] {
    OpInsert  = 2'd0,
    OpOverlap = 2'd1,
    OpDrop    = 2'd2,
    OpNone    = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] z;
    logic [CoordBits-1:0] r;
  } sphere_t;

  // square root request / response between scan and root unit
  typedef struct packed {
    logic              start;
    logic [SqBits-1:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [RootBits-1:0] root;
  } root_rsp_t;
endpackage

### rtl/sphere_table_drop_contact_search.sv
// top level: sphere table with insert, overlap and drop queries
//
// Input stream s_axis carries one request per item: opcode, centre x, y, z
// and radius. Output stream m_axis returns one result per request: found,
// hit index, new z and status. The user must write contact_epsilon through cfg_we_i /
// cfg_wdata_i only while the block is idle (not enforced by the block); it resets to 1.
//
// One request is processed at a time. Insert and unknown opcodes pass
// through StOut into the output register. Overlap scans the table newest
// to oldest through the single read port, each entry going through StRead
// and StEval, stopping at the first hit. Drop scans all entries; each hit
// entry also waits in StRoot for the 25-step bit-serial square root unit.
//
// Reset empties the table (the count goes to zero; memory is not cleared).
// A finished result waits in the output register while the receiver stalls;
// the next request is taken the cycle after that result has been delivered.
module sphere_table_drop_contact_search
  import stdc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] opcode, [25:2] pos_x, [49:26] pos_y, [73:50] pos_z, [97:74] radius
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] found, [12:1] hit_index, [36:13] new_z, [37] status
  output logic [39:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i
);
  typedef enum logic [2:0] {
    StIdle, StRead, StEval, StRoot, StOut
  } state_e;

  state_e               state_q;
  logic [1:0]           op_q;
  sphere_t              in_q;
  logic [CoordBits-1:0] eps_q;
  logic [CntBits-1:0]   count_q;
  logic [CntBits-1:0]   ptr_q;
  logic [IdxBits-1:0]   cur_q;
  logic                 taken_q;
  logic [IdxBits-1:0]   bidx_q;
  logic [RootBits:0]    best_q;
  logic [CoordBits-1:0] cz_q;
  logic                 found_q, status_q, ovalid_q;
  logic [IdxBits-1:0]   hit_q;
  logic [CoordBits-1:0] newz_q;

  sphere_t              rd;
  sphere_t              in_w;
  root_req_t            rreq;
  root_rsp_t            rrsp;
  logic [IdxBits-1:0]   rd_addr;

  assign in_w.x = s_axis_tdata[25:2];
  assign in_w.y = s_axis_tdata[49:26];
  assign in_w.z = s_axis_tdata[73:50];
  assign in_w.r = s_axis_tdata[97:74];

  // address the next entry while stepping so its data is ready for eval
  assign rd_addr = (state_q == StRead) ? IdxBits'(ptr_q - 1'b1) : cur_q;

  stdc_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == StIdle && s_axis_tvalid && !ovalid_q &&
                opcode_e'(s_axis_tdata[1:0]) == OpInsert && !count_q[CntBits-1]),
    .wr_addr_i (count_q[IdxBits-1:0]),
    .wr_data_i (in_w),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd)
  );

  // geometry of the current entry
  logic [CoordBits-1:0] dx, dy, dz;
  logic [SqBits-1:0]    dx2, dy2, dz2;
  logic [SqBits+1:0]    h2, d2, s2, t2;
  logic [CoordBits:0]   rsum, thr;
  logic                 thr_pos, close_h, close_d;

  always_comb begin
    dx   = (in_q.x > rd.x) ? in_q.x - rd.x : rd.x - in_q.x;
    dy   = (in_q.y > rd.y) ? in_q.y - rd.y : rd.y - in_q.y;
    dz   = (in_q.z > rd.z) ? in_q.z - rd.z : rd.z - in_q.z;
    dx2  = SqBits'(dx) * SqBits'(dx);
    dy2  = SqBits'(dy) * SqBits'(dy);
    dz2  = SqBits'(dz) * SqBits'(dz);
    h2   = (SqBits+2)'(dx2) + (SqBits+2)'(dy2);
    d2   = h2 + (SqBits+2)'(dz2);
    rsum = {1'b0, in_q.r} + {1'b0, rd.r};
    thr_pos = rsum > {1'b0, eps_q};
    thr  = rsum - {1'b0, eps_q};
    t2   = (SqBits+2)'(thr) * (SqBits+2)'(thr);
    s2   = (SqBits+2)'(rsum) * (SqBits+2)'(rsum);
    close_h = thr_pos && (h2 < t2);
    close_d = thr_pos && (d2 < t2);
  end

  assign rreq.start    = (state_q == StEval) && (op_q == OpDrop) &&
                         (in_q.z >= rd.z) && close_h;
  assign rreq.radicand = SqBits'(s2 - h2);

  stdc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rreq),
    .rsp_o  (rrsp)
  );

  logic [RootBits:0] zc;
  assign zc = {2'b0, cz_q} + {1'b0, rrsp.root};

  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;

  // epsilon register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) eps_q <= 24'd1;
    else if (cfg_we_i) eps_q <= cfg_wdata_i;
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      ptr_q    <= '0;
      cur_q    <= '0;
      op_q     <= OpNone;
      taken_q  <= 1'b0;
      bidx_q   <= '0;
      best_q   <= '0;
      cz_q     <= '0;
      found_q  <= 1'b0;
      status_q <= 1'b0;
      hit_q    <= '0;
      newz_q   <= '0;
      in_q     <= '0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op_q    <= s_axis_tdata[1:0];
            in_q    <= in_w;
            found_q <= 1'b0;
            hit_q   <= '0;
            newz_q  <= in_w.z;
            status_q <= 1'b0;
            taken_q <= 1'b0;
            best_q  <= '0;
            bidx_q  <= '0;
            ptr_q   <= count_q;
            unique case (opcode_e'(s_axis_tdata[1:0]))
              OpInsert: begin
                if (count_q[CntBits-1]) status_q <= 1'b1;
                else begin
                  hit_q   <= count_q[IdxBits-1:0];
                  count_q <= count_q + 1'b1;
                end
                state_q <= StOut;
              end
              OpOverlap, OpDrop: state_q <= StRead;
              default: state_q <= StOut;
            endcase
          end
        end
        StRead: begin
          if (ptr_q == '0) begin
            if (op_q == OpDrop) begin
              if (taken_q && {1'b0, in_q.z} > best_q[CoordBits:0] &&
                  best_q[RootBits:CoordBits+1] == '0) begin
                found_q <= 1'b1;
                hit_q   <= bidx_q;
                newz_q  <= best_q[CoordBits-1:0];
              end else begin
                newz_q <= in_q.r;
              end
            end
            state_q <= StOut;
          end else begin
            cur_q   <= IdxBits'(ptr_q - 1'b1);
            ptr_q   <= ptr_q - 1'b1;
            state_q <= StEval;
          end
        end
        StEval: begin
          cz_q <= rd.z;
          if (op_q == OpOverlap && close_d) begin
            found_q <= 1'b1;
            hit_q   <= cur_q;
            state_q <= StOut;
          end else if (rreq.start) begin
            state_q <= StRoot;
          end else begin
            state_q <= StRead;
          end
        end
        StRoot: begin
          if (rrsp.done) begin
            if (zc > best_q && {2'b0, in_q.z} > best_q) begin
              best_q  <= zc;
              bidx_q  <= cur_q;
              taken_q <= 1'b1;
            end
            state_q <= StRead;
          end
        end
        StOut: begin
          ovalid_q <= 1'b1;
          state_q  <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, status_q, newz_q, hit_q, found_q};
endmodule

### rtl/stdc_store.sv
// sphere table memory, one write and one registered read port
module stdc_store
  import stdc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [IdxBits-1:0]    wr_addr_i,
  input  sphere_t               wr_data_i,
  input  logic [IdxBits-1:0]    rd_addr_i,
  output sphere_t               rd_data_o
);
  logic [2*CoordBits-1:0] xy_mem [Capacity];
  logic [2*CoordBits-1:0] zr_mem [Capacity];
  logic [2*CoordBits-1:0] xy_q, zr_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      xy_mem[wr_addr_i] <= {wr_data_i.y, wr_data_i.x};
      zr_mem[wr_addr_i] <= {wr_data_i.r, wr_data_i.z};
    end
    xy_q <= xy_mem[rd_addr_i];
    zr_q <= zr_mem[rd_addr_i];
  end

  assign rd_data_o.x = xy_q[CoordBits-1:0];
  assign rd_data_o.y = xy_q[2*CoordBits-1:CoordBits];
  assign rd_data_o.z = zr_q[CoordBits-1:0];
  assign rd_data_o.r = zr_q[2*CoordBits-1:CoordBits];
endmodule

### rtl/stdc_sqrt.sv
// bit-serial floor square root, one result bit per cycle
module stdc_sqrt
  import stdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  root_req_t req_i,
  output root_rsp_t rsp_o
);
  localparam int unsigned RemBits = SqBits + 4;
  localparam int unsigned StepBits = $clog2(RootBits + 1);

  logic [SqBits+1:0]     val_q, val_d;
  logic [RemBits-1:0]    rem_q, rem_d;
  logic [RootBits-1:0]   root_q, root_d;
  logic [StepBits-1:0]   step_q, step_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [RemBits-1:0]    trial;
  logic [RemBits-1:0]    shifted;

  // restoring digit recurrence
  always_comb begin
    shifted = {rem_q[RemBits-3:0], val_q[SqBits+1:SqBits]};
    trial   = {{(RemBits-RootBits-2){1'b0}}, root_q, 2'b01};
    val_d   = val_q;
    rem_d   = rem_q;
    root_d  = root_q;
    step_d  = step_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      // top digit pair of the radicand lands in the two msbs
      val_d  = {req_i.radicand, 2'b00};
      rem_d  = '0;
      root_d = '0;
      step_d = StepBits'(RootBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[SqBits-1:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[RootBits-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;
endmodule

### rtl/stdc_checker.sv
// port-level checker for the sphere table, bound to the top level
module stdc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata
);
  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // no new request while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

  // a request gets no result in the very next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

  // refused insert never reports a hit
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[37] |-> !m_axis_tdata[0])
    else $error("status and found both set");
endmodule

bind sphere_table_drop_contact_search stdc_checker u_stdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
